// ===== design/text_command_line_parser_macros.svh =====
// ----------------------------------------------------------------------------
// text_command_line_parser_macros
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef TEXT_COMMAND_LINE_PARSER_MACROS_SVH
`define TEXT_COMMAND_LINE_PARSER_MACROS_SVH

// same-cycle implication, quiet during reset
`define TCLP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define TCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tclp_pkg.sv =====
// ----------------------------------------------------------------------------
// tclp_pkg
// types, keyword tables and character helpers of the command line parser
// ----------------------------------------------------------------------------
package tclp_pkg;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_PING     = 3'd1,
    CMD_SEARCH   = 3'd2,
    CMD_STORE    = 3'd3,
    CMD_SHUTDOWN = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    PH_LEAD = 4'b0001,
    PH_VERB = 4'b0010,
    PH_GAP  = 4'b0100,
    PH_ARG  = 4'b1000
  } phase_t;

  localparam int          KW_NUM     = 4;
  localparam int          KW_MAX_LEN = 8;
  localparam logic [7:0]  CHAR_NUL   = 8'h00;
  localparam logic [7:0]  CHAR_LF    = 8'h0a;
  localparam logic [7:0]  CHAR_CR    = 8'h0d;

  // upper-case spelling of each verb, padded with zeros
  localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
    '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "E", "A", "R", "C", "H", 8'h00, 8'h00},
    '{"S", "T", "O", "R", "E", 8'h00, 8'h00, 8'h00},
    '{"S", "H", "U", "T", "D", "O", "W", "N"}
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd4, 4'd6, 4'd5, 4'd8};

  typedef struct packed {
    logic       arg_write;
    logic [7:0] arg_char;
    logic [7:0] arg_index;
    logic       done_res;
    cmd_t       command_type;
    logic       parse_ok;
    logic       cmd_valid;
    logic [7:0] arg_length;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'd97) && (c <= 8'd122)) ? (c - 8'd32) : c;
  endfunction

endpackage

// ===== design/tclp_kw_unit.sv =====
// ----------------------------------------------------------------------------
// tclp_kw_unit
// per-keyword match tracking for one verb character, and verb decode
// ----------------------------------------------------------------------------
module tclp_kw_unit import tclp_pkg::*; #(
  parameter int VW = 5
) (
  input  logic [KW_NUM-1:0] match_i,
  input  logic [VW-1:0]     vcnt_i,
  input  logic [7:0]        chr_i,
  output logic [KW_NUM-1:0] match_o,
  input  logic [KW_NUM-1:0] fin_match_i,
  input  logic [VW-1:0]     fin_vcnt_i,
  output cmd_t              cmd_o
);

  logic [7:0] up_chr;

  assign up_chr = to_upper(chr_i);

  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      // past the keyword length nothing can match
      if (vcnt_i >= VW'(KW_LEN[k])) begin
        match_o[k] = 1'b0;
      end else begin
        match_o[k] = match_i[k] && (KW_TEXT[k][vcnt_i[2:0]] == up_chr);
      end
    end
  end

  always_comb begin
    cmd_o = CMD_NONE;
    for (int k = 0; k < KW_NUM; k++) begin
      if (fin_match_i[k] && (fin_vcnt_i == VW'(KW_LEN[k]))) begin
        cmd_o = cmd_t'(3'(k + 1));
      end
    end
  end

endmodule

// ===== design/tclp_parse.sv =====
// ----------------------------------------------------------------------------
// tclp_parse
// line state registers and the single-pass next-state and result logic
// ----------------------------------------------------------------------------
module tclp_parse import tclp_pkg::*; #(
  parameter int LINE_BYTES = 1024,
  parameter int VERB_BYTES = 32,
  parameter int ARG_BYTES  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] chr,
  input  logic       last,
  output res_t       res
);

  localparam int LW = $clog2(LINE_BYTES);
  localparam int VW = $clog2(VERB_BYTES);
  localparam int AW = $clog2(ARG_BYTES);
  localparam logic [LW-1:0] LINE_LIM = LW'(LINE_BYTES - 1);
  localparam logic [VW-1:0] VERB_LIM = VW'(VERB_BYTES - 1);
  localparam logic [AW-1:0] ARG_LIM  = AW'(ARG_BYTES - 1);

  phase_t            phase_r, phase_nxt;
  logic [LW-1:0]     line_cnt_r, line_cnt_nxt;
  logic [VW-1:0]     verb_cnt_r, verb_cnt_nxt;
  logic [KW_NUM-1:0] match_r, match_nxt, match_upd;
  logic [AW-1:0]     seen_r, seen_nxt;
  logic [AW-1:0]     kept_r, kept_nxt;
  logic              term_r, term_nxt;
  logic              ws;
  logic              handled;
  cmd_t              fin_cmd;
  logic [AW+7:0]     seen_ext;
  logic [AW+7:0]     kept_ext;

  tclp_kw_unit #(.VW(VW)) u_kw (
    .match_i     (match_r),
    .vcnt_i      (verb_cnt_r),
    .chr_i       (chr),
    .match_o     (match_upd),
    .fin_match_i (match_nxt),
    .fin_vcnt_i  (verb_cnt_nxt),
    .cmd_o       (fin_cmd)
  );

  assign ws       = is_ws(chr);
  assign seen_ext = {8'd0, seen_r};
  assign kept_ext = {8'd0, kept_nxt};

  always_comb begin
    phase_nxt    = phase_r;
    line_cnt_nxt = line_cnt_r;
    verb_cnt_nxt = verb_cnt_r;
    match_nxt    = match_r;
    seen_nxt     = seen_r;
    kept_nxt     = kept_r;
    term_nxt     = term_r;
    handled      = 1'b0;
    res          = '0;

    if (!term_r && (line_cnt_r < LINE_LIM)) begin
      if (chr == CHAR_NUL) begin
        term_nxt = 1'b1;
      end else begin
        line_cnt_nxt = line_cnt_r + 1'b1;
        // phases fall through within one character
        if (phase_nxt == PH_LEAD) begin
          if (ws) begin
            handled = 1'b1;
          end else begin
            phase_nxt = PH_VERB;
          end
        end
        if (!handled && (phase_nxt == PH_VERB)) begin
          if (!ws && (verb_cnt_r < VERB_LIM)) begin
            match_nxt    = match_upd;
            verb_cnt_nxt = verb_cnt_r + 1'b1;
            handled      = 1'b1;
          end else begin
            phase_nxt = PH_GAP;
          end
        end
        if (!handled && (phase_nxt == PH_GAP)) begin
          if (ws) begin
            handled = 1'b1;
          end else begin
            phase_nxt = PH_ARG;
          end
        end
        if (!handled && (phase_nxt == PH_ARG)) begin
          if (seen_r < ARG_LIM) begin
            res.arg_write = 1'b1;
            res.arg_char  = chr;
            res.arg_index = seen_ext[7:0];
          end
          // trailing cr/lf do not count toward the length
          if ((chr != CHAR_LF) && (chr != CHAR_CR)) begin
            kept_nxt = (seen_r == ARG_LIM) ? ARG_LIM : (seen_r + 1'b1);
          end
          // saturating at the buffer limit; it also gives the argument index and length
          if (seen_r != ARG_LIM) begin
            seen_nxt = seen_r + 1'b1;
          end
        end
      end
    end

    if (last) begin
      res.done_res     = 1'b1;
      res.command_type = fin_cmd;
      res.parse_ok     = (fin_cmd != CMD_NONE);
      if ((fin_cmd == CMD_SEARCH) || (fin_cmd == CMD_STORE)) begin
        res.cmd_valid = (kept_nxt != '0);
      end else begin
        res.cmd_valid = (fin_cmd != CMD_NONE);
      end
      res.arg_length = kept_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      line_cnt_r <= '0;
      verb_cnt_r <= '0;
      match_r    <= '1;
      seen_r     <= '0;
      kept_r     <= '0;
      term_r     <= 1'b0;
    end else if (step) begin
      if (last) begin
        phase_r    <= PH_LEAD;
        line_cnt_r <= '0;
        verb_cnt_r <= '0;
        match_r    <= '1;
        seen_r     <= '0;
        kept_r     <= '0;
        term_r     <= 1'b0;
      end else begin
        phase_r    <= phase_nxt;
        line_cnt_r <= line_cnt_nxt;
        verb_cnt_r <= verb_cnt_nxt;
        match_r    <= match_nxt;
        seen_r     <= seen_nxt;
        kept_r     <= kept_nxt;
        term_r     <= term_nxt;
      end
    end
  end

endmodule

// ===== design/text_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// text_command_line_parser
// streaming parser for one text command line, one byte per item
// ----------------------------------------------------------------------------
// usage:
//   in_*  channel: one line byte per item (in_byte, in_last marks the end).
//   out_* channel: exactly one result item per input item, in order.
//   a result carries an argument character with its index when the byte
//   belongs to the argument within the buffer cap; the result for the last byte also carries the
//   command type, parse_ok, cmd_valid and the trimmed argument length.
// order: a byte is held in the input register, then its result is captured in the result register and offered.
// throughput: one byte per cycle while out_ready stays high; the input
//   register feeds the combinational parse logic into the result register.
// stall: while out_ready is low the result register holds; the input
//   register takes one more byte only if it is empty, then in_ready drops until the
//   result moves on.
// reset: synchronous active-low rst_n empties both registers and returns
//   the line state to leading-whitespace skip; no clearing pass is needed.
// ----------------------------------------------------------------------------
module text_command_line_parser import tclp_pkg::*; #(
  parameter int LINE_BYTES = 1024,
  parameter int VERB_BYTES = 32,
  parameter int ARG_BYTES  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_arg_write,
  output logic [7:0] out_arg_char,
  output logic [7:0] out_arg_index,
  output logic       out_done_res,
  output logic [2:0] out_command_type,
  output logic       out_parse_ok,
  output logic       out_cmd_valid,
  output logic [7:0] out_arg_length
);

  logic       in_vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       out_vld_r;
  res_t       res_r;
  res_t       res_nxt;
  logic       advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  tclp_parse #(
    .LINE_BYTES (LINE_BYTES),
    .VERB_BYTES (VERB_BYTES),
    .ARG_BYTES  (ARG_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .chr   (byte_r),
    .last  (last_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_arg_write    = res_r.arg_write;
  assign out_arg_char     = res_r.arg_char;
  assign out_arg_index    = res_r.arg_index;
  assign out_done_res     = res_r.done_res;
  assign out_command_type = res_r.command_type;
  assign out_parse_ok     = res_r.parse_ok;
  assign out_cmd_valid    = res_r.cmd_valid;
  assign out_arg_length   = res_r.arg_length;

endmodule

// ===== design/tclp_checker.sv =====
// ----------------------------------------------------------------------------
// tclp_checker
// port-level checks of the command line parser, bound to the top level
// ----------------------------------------------------------------------------
`include "text_command_line_parser_macros.svh"

module tclp_checker import tclp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_arg_write,
  input logic [7:0] out_arg_char,
  input logic [7:0] out_arg_index,
  input logic       out_done_res,
  input logic [2:0] out_command_type,
  input logic       out_parse_ok,
  input logic       out_cmd_valid,
  input logic [7:0] out_arg_length
);

  // a stalled result stays offered
  `TCLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // summary fields are zero except on the line-end item
  `TCLP_ASSERT_IMPL(a_sum_zero, out_valid && !out_done_res, (out_command_type == CMD_NONE) && !out_parse_ok && !out_cmd_valid && (out_arg_length == 8'd0), "summary on a mid-line item")

  // no argument write means empty character and index
  `TCLP_ASSERT_IMPL(a_arg_zero, out_valid && !out_arg_write, (out_arg_char == 8'd0) && (out_arg_index == 8'd0), "stray argument data")

  // a valid command is a recognized verb
  `TCLP_ASSERT_IMPL(a_valid_ok, out_valid && out_cmd_valid, out_parse_ok && (out_command_type != CMD_NONE), "valid command without a verb")

endmodule

bind text_command_line_parser tclp_checker u_tclp_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming command line parser
// ----------------------------------------------------------------------------
// whole text lines go in byte by byte: a few corner lines, one oversized line
// with a long argument, then random lines that are mostly well-formed verbs
// with random case and arguments, plus noise. a line-state model predicts the
// result item of every accepted byte and each result is compared field by
// field. four idling mixes on the sender and receiver side are run in turn.
// ----------------------------------------------------------------------------
module tb_top import tclp_pkg::*; ();

  localparam int LINE_BYTES    = 1024;
  localparam int VERB_BYTES    = 32;
  localparam int ARG_BYTES     = 256;
  localparam int ITEMS_PER_MIX = 100;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PRINT_LIMIT   = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } line_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic       out_arg_write;
  logic [7:0] out_arg_char;
  logic [7:0] out_arg_index;
  logic       out_done_res;
  logic [2:0] out_command_type;
  logic       out_parse_ok;
  logic       out_cmd_valid;
  logic [7:0] out_arg_length;

  line_byte_t pending_bytes[$];
  logic [7:0] line_buf[$];
  res_t       expected_res[$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         error_count;
  int         result_count;
  int         pushed_count;
  int         quiet_cycles;

  // line state of the parser model
  phase_t     lp_phase;
  logic [9:0] lp_line_cnt;
  logic [4:0] lp_verb_cnt;
  logic [3:0] lp_kw_match;
  logic [9:0] lp_arg_seen;
  logic [9:0] lp_arg_kept;
  logic       lp_ended;

  text_command_line_parser #(
    .LINE_BYTES(LINE_BYTES),
    .VERB_BYTES(VERB_BYTES),
    .ARG_BYTES (ARG_BYTES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_arg_write   (out_arg_write),
    .out_arg_char    (out_arg_char),
    .out_arg_index   (out_arg_index),
    .out_done_res    (out_done_res),
    .out_command_type(out_command_type),
    .out_parse_ok    (out_parse_ok),
    .out_cmd_valid   (out_cmd_valid),
    .out_arg_length  (out_arg_length)
  );

  function automatic logic [63:0] kw_spell(int k);
    case (k)
      0: return "PING";
      1: return "SEARCH";
      2: return "STORE";
      default: return "SHUTDOWN";
    endcase
  endfunction

  function automatic int kw_size(int k);
    case (k)
      0: return 4;
      1: return 6;
      2: return 5;
      default: return 8;
    endcase
  endfunction

  // upper-case letter at position pos of verb k, zero past its end
  function automatic logic [7:0] verb_letter(int k, int pos);
    logic [63:0] spell;
    spell = kw_spell(k);
    if (pos >= kw_size(k)) return 8'h00;
    return spell[8*(kw_size(k)-1-pos) +: 8];
  endfunction

  function automatic void clear_line();
    lp_phase    = PH_LEAD;
    lp_line_cnt = '0;
    lp_verb_cnt = '0;
    lp_kw_match = 4'hf;
    lp_arg_seen = '0;
    lp_arg_kept = '0;
    lp_ended    = 1'b0;
  endfunction

  function automatic res_t predict_result(logic [7:0] ch, logic fin);
    res_t       r;
    logic       ws;
    logic       taken;
    logic [7:0] up;
    cmd_t       kind;
    r = '0;
    if (!lp_ended && lp_line_cnt < LINE_BYTES - 1) begin
      if (ch == CHAR_NUL) begin
        lp_ended = 1'b1;
      end else begin
        ws    = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0d);
        taken = 1'b0;
        lp_line_cnt++;
        if (lp_phase == PH_LEAD) begin
          if (ws) taken = 1'b1;
          else lp_phase = PH_VERB;
        end
        if (!taken && lp_phase == PH_VERB) begin
          if (!ws && lp_verb_cnt < VERB_BYTES - 1) begin
            up = (ch >= 8'h61 && ch <= 8'h7a) ? ch - 8'h20 : ch;
            for (int k = 0; k < 4; k++) begin
              if (lp_verb_cnt >= kw_size(k) || verb_letter(k, lp_verb_cnt) != up)
                lp_kw_match[k] = 1'b0;
            end
            lp_verb_cnt++;
            taken = 1'b1;
          end else begin
            lp_phase = PH_GAP;
          end
        end
        if (!taken && lp_phase == PH_GAP) begin
          if (ws) taken = 1'b1;
          else lp_phase = PH_ARG;
        end
        if (!taken && lp_phase == PH_ARG) begin
          if (lp_arg_seen < ARG_BYTES - 1) begin
            r.arg_write = 1'b1;
            r.arg_char  = ch;
            r.arg_index = lp_arg_seen[7:0];
          end
          // trailing cr/lf do not count toward the length
          if (ch != CHAR_LF && ch != CHAR_CR)
            lp_arg_kept = (int'(lp_arg_seen) + 1 > ARG_BYTES - 1) ?
                          10'(ARG_BYTES - 1) : lp_arg_seen + 10'd1;
          lp_arg_seen++;
        end
      end
    end
    if (fin) begin
      kind = CMD_NONE;
      for (int k = 0; k < 4; k++) begin
        if (lp_kw_match[k] && kw_size(k) == lp_verb_cnt) kind = cmd_t'(3'(k + 1));
      end
      r.done_res     = 1'b1;
      r.command_type = kind;
      r.parse_ok     = (kind != CMD_NONE);
      if (kind == CMD_SEARCH || kind == CMD_STORE) r.cmd_valid = (lp_arg_kept != 0);
      else r.cmd_valid = (kind != CMD_NONE);
      r.arg_length = lp_arg_kept[7:0];
      clear_line();
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(5))
      0: return 8'h09;
      1: return 8'h0a;
      2: return 8'h0b;
      3: return 8'h0c;
      4: return 8'h0d;
      default: return 8'h20;
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // move the collected line into the item queue, last flag on its final byte
  function automatic void flush_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      pending_bytes.push_back({line_buf[i], i == line_buf.size() - 1});
      pushed_count++;
    end
    line_buf.delete();
  endfunction

  function automatic void random_line();
    int kind;
    int k;
    int n;
    kind = $urandom_range(99);
    repeat ($urandom_range(2)) line_buf.push_back(pick_blank());
    if (kind < 65) begin
      // known verb in random case
      k = $urandom_range(3);
      for (int p = 0; p < kw_size(k); p++)
        line_buf.push_back(verb_letter(k, p) | ($urandom_range(1) ? 8'h20 : 8'h00));
    end else if (kind < 75) begin
      // verb prefix, or verb with one letter too many
      k = $urandom_range(3);
      n = $urandom_range(kw_size(k) + 1, 1);
      for (int p = 0; p < n; p++)
        line_buf.push_back(p < kw_size(k) ? verb_letter(k, p) : 8'h58);
    end else if (kind < 83) begin
      repeat ($urandom_range(10, 1)) line_buf.push_back(8'($urandom_range(126, 33)));
    end else if (kind < 88) begin
      // long verb near the verb buffer limit, which may overrun it into the argument
      k = $urandom_range(3);
      for (int p = 0; p < kw_size(k); p++) line_buf.push_back(verb_letter(k, p));
      n = $urandom_range(VERB_BYTES + 8, VERB_BYTES - 3);
      while (line_buf.size() < n) line_buf.push_back(8'h61 + 8'($urandom_range(25)));
    end else begin
      repeat ($urandom_range(8)) line_buf.push_back(8'($urandom_range(255)));
    end
    if (kind < 88) begin
      if ($urandom_range(3) != 0) repeat ($urandom_range(2, 1)) line_buf.push_back(pick_blank());
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
      repeat (n) begin
        if ($urandom_range(4) == 0) line_buf.push_back(8'($urandom_range(255, 1)));
        else line_buf.push_back(8'($urandom_range(126, 32)));
      end
      case ($urandom_range(5))
        0: begin
          line_buf.push_back(CHAR_CR);
          line_buf.push_back(CHAR_LF);
        end
        1: line_buf.push_back(CHAR_LF);
        2: line_buf.push_back(CHAR_CR);
        default: ;
      endcase
    end
    if ($urandom_range(19) == 0 && line_buf.size() > 0)
      line_buf[$urandom_range(line_buf.size() - 1)] = CHAR_NUL;
    if (line_buf.size() == 0) line_buf.push_back(pick_blank());
    flush_line();
  endfunction

  task automatic report(string msg);
    // keep the log short on a badly broken block, count everything
    if (error_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", result_count, name, got, want));
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // driver: predicts on acceptance, then offers the next item or idles
  always @(posedge clk) begin
    line_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_res.push_back(predict_result(in_byte, in_last));
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte  <= nxt.ch;
          in_last  <= nxt.fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_res.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = expected_res.pop_front();
          check_field("arg_write", 8'(out_arg_write), 8'(want.arg_write));
          check_field("arg_char", out_arg_char, want.arg_char);
          check_field("arg_index", out_arg_index, want.arg_index);
          check_field("done_res", 8'(out_done_res), 8'(want.done_res));
          check_field("command_type", 8'(out_command_type), 8'(want.command_type));
          check_field("parse_ok", 8'(out_parse_ok), 8'(want.parse_ok));
          check_field("cmd_valid", 8'(out_cmd_valid), 8'(want.cmd_valid));
          check_field("arg_length", out_arg_length, want.arg_length);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_last        = 1'b0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    result_count   = 0;
    pushed_count   = 0;
    quiet_cycles   = 0;
    clear_line();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int mix = 0; mix < 4; mix++) begin
      @(negedge clk);
      case (mix)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      // the corner lines count toward the first mix
      pushed_count = 0;
      if (mix == 0) begin
        line_buf.push_back(CHAR_NUL);
        flush_line();
        add_text(" \t");
        flush_line();
        add_text("ping");
        flush_line();
        add_text("SeArCh");
        flush_line();
        add_text("store ");
        line_buf.push_back(8'hff);
        line_buf.push_back(CHAR_CR);
        flush_line();
        add_text("shutdown");
        flush_line();
        // argument past the buffer cap, then the line past its byte limit
        add_text("search ");
        repeat (400) line_buf.push_back(8'($urandom_range(255, 1)));
        while (line_buf.size() < LINE_BYTES + 8)
          line_buf.push_back(8'($urandom_range(126, 33)));
        flush_line();
      end
      while (pushed_count < ITEMS_PER_MIX) random_line();
      // hold the next mix back until every result has come
      while (pending_bytes.size() != 0 || in_valid || expected_res.size() != 0)
        @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_res.size() != 0)
      report($sformatf("%0d results never arrived", expected_res.size()));
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/tclp_pkg.sv
design/tclp_kw_unit.sv
design/tclp_parse.sv
design/text_command_line_parser.sv
design/tclp_checker.sv
verif/tb_top.sv
